>>> sv/lacc_pkg.sv
// Package for the LE advertising command checker: command, result and settings
// types, operation and status codes, range limits.
// No dependencies.
package lacc_pkg;

  localparam int unsigned OpW       = 3;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned AddrW     = 48;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 5;

  localparam logic [IntervalW-1:0] IntervalHigh      = 16'h4000;
  localparam logic [IntervalW-1:0] IntervalLowConn    = 16'h0020;
  localparam logic [IntervalW-1:0] IntervalLowNonconn = 16'h00a0;
  localparam logic [IntervalW-1:0] IntervalReset      = 16'h0800;
  localparam logic [ByteW-1:0]     MaxDataLen         = 8'h1f;
  localparam logic [2:0]           ChannelsReset      = 3'h7;

  typedef enum logic [OpW-1:0] {
    OP_SET_PARAMS = 3'd0,
    OP_SET_ENABLE = 3'd1,
    OP_ADV_LEN    = 3'd2,
    OP_SCAN_LEN   = 3'd3,
    OP_RESET      = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INVALID    = 2'd1,
    ST_DISALLOWED = 2'd2
  } status_e;

  typedef enum logic {
    EV_COMPLETE = 1'b0,
    EV_STATUS   = 1'b1
  } event_e;

  typedef enum logic [1:0] {
    ADV_IND     = 2'd0,
    ADV_DIRECT  = 2'd1,
    ADV_SCAN    = 2'd2,
    ADV_NONCONN = 2'd3
  } adv_type_e;

  typedef struct packed {
    logic [OpW-1:0]       operation;
    logic [IntervalW-1:0] interval_lo;
    logic [IntervalW-1:0] interval_hi;
    logic [ByteW-1:0]     adv_type;
    logic [ByteW-1:0]     own_address_kind;
    logic [ByteW-1:0]     peer_address_kind;
    logic [AddrW-1:0]     peer_address;
    logic [ByteW-1:0]     channel_select;
    logic [ByteW-1:0]     filter_mode;
    logic [ByteW-1:0]     enable_request;
    logic [ByteW-1:0]     payload_length;
  } cmd_t;

  typedef struct packed {
    status_e status;
    event_e  event_kind;
    logic    advertising_on;
  } rsp_t;

  typedef struct packed {
    logic [IntervalW-1:0] interval_lo;
    logic [IntervalW-1:0] interval_hi;
    logic [1:0]           adv_type;
    logic                 own_kind;
    logic [ByteW-1:0]     peer_kind;
    logic [AddrW-1:0]     peer_address;
    logic [2:0]           channels;
    logic [1:0]           filter;
    logic                 adv_enabled;
    logic [LenW-1:0]      adv_data_length;
    logic [LenW-1:0]      scan_data_length;
  } settings_t;

  localparam settings_t SettingsReset = '{
    interval_lo:      IntervalReset,
    interval_hi:      IntervalReset,
    adv_type:         2'd0,
    own_kind:         1'b0,
    peer_kind:        '0,
    peer_address:     '0,
    channels:         ChannelsReset,
    filter:           2'd0,
    adv_enabled:      1'b0,
    adv_data_length:  '0,
    scan_data_length: '0
  };

endpackage

>>> sv/lacc_if.sv
// Valid/ready channel interfaces for command words and result words.
// Depends on lacc_pkg for field widths.
interface lacc_cmd_if import lacc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OpW-1:0]       operation;
  logic [IntervalW-1:0] interval_lo;
  logic [IntervalW-1:0] interval_hi;
  logic [ByteW-1:0]     adv_type;
  logic [ByteW-1:0]     own_address_kind;
  logic [ByteW-1:0]     peer_address_kind;
  logic [AddrW-1:0]     peer_address;
  logic [ByteW-1:0]     channel_select;
  logic [ByteW-1:0]     filter_mode;
  logic [ByteW-1:0]     enable_request;
  logic [ByteW-1:0]     payload_length;

  modport source (
    output valid, operation, interval_lo, interval_hi, adv_type, own_address_kind,
           peer_address_kind, peer_address, channel_select, filter_mode,
           enable_request, payload_length,
    input  ready
  );
  modport sink (
    input  valid, operation, interval_lo, interval_hi, adv_type, own_address_kind,
           peer_address_kind, peer_address, channel_select, filter_mode,
           enable_request, payload_length,
    output ready
  );
endinterface

interface lacc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       event_kind;
  logic       advertising_on;

  modport source (output valid, status, event_kind, advertising_on, input ready);
  modport sink   (input valid, status, event_kind, advertising_on, output ready);
endinterface

>>> sv/lacc_check.sv
// Command decode and parameter checks: gives the result word and the settings
// after the command. Purely combinational. Depends on lacc_pkg.
module lacc_check import lacc_pkg::*; (
  input  cmd_t      cmd_i,
  input  settings_t cur_i,
  output rsp_t      rsp_o,
  output settings_t nxt_o
);

  logic [IntervalW-1:0] lo_bound;
  logic                 interval_ok;
  status_e              par_status;
  status_e              status;

  // Bounds per advertising type: connectable undirected uses the lower floor.
  always_comb begin
    lo_bound = (cmd_i.adv_type == ByteW'(ADV_IND)) ? IntervalLowConn : IntervalLowNonconn;
    interval_ok = (cmd_i.interval_lo >= lo_bound) && (cmd_i.interval_lo <= IntervalHigh) &&
                  (cmd_i.interval_hi >= lo_bound) && (cmd_i.interval_hi <= IntervalHigh) &&
                  (cmd_i.interval_lo <= cmd_i.interval_hi);
  end

  // Set parameters checks, in priority order.
  always_comb begin
    par_status = ST_OK;
    if (cur_i.adv_enabled) begin
      par_status = ST_DISALLOWED;
    end else if (cmd_i.adv_type > ByteW'(ADV_NONCONN)) begin
      par_status = ST_INVALID;
    end else if (cmd_i.adv_type == ByteW'(ADV_DIRECT)) begin
      if (cmd_i.peer_address_kind > 8'd1) par_status = ST_INVALID;
    end else if (!interval_ok) begin
      par_status = ST_INVALID;
    end
    if (par_status == ST_OK) begin
      if (cmd_i.own_address_kind > 8'd1) begin
        par_status = ST_INVALID;
      end else if (!(cmd_i.channel_select inside {[8'd1:8'd7]})) begin
        par_status = ST_INVALID;
      end else if (cmd_i.filter_mode > 8'd3) begin
        par_status = ST_INVALID;
      end
    end
  end

  always_comb begin
    nxt_o  = cur_i;
    status = ST_INVALID;
    case (op_e'(cmd_i.operation))
      OP_SET_PARAMS: begin
        status = par_status;
        if (par_status == ST_OK) begin
          nxt_o.interval_lo  = cmd_i.interval_lo;
          nxt_o.interval_hi  = cmd_i.interval_hi;
          nxt_o.adv_type     = cmd_i.adv_type[1:0];
          nxt_o.own_kind     = cmd_i.own_address_kind[0];
          nxt_o.peer_kind    = cmd_i.peer_address_kind;
          nxt_o.peer_address = cmd_i.peer_address;
          nxt_o.channels     = cmd_i.channel_select[2:0];
          nxt_o.filter       = cmd_i.filter_mode[1:0];
        end
      end
      OP_SET_ENABLE: begin
        if (cmd_i.enable_request > 8'd1) begin
          status = ST_INVALID;
        end else if (cmd_i.enable_request[0] == cur_i.adv_enabled) begin
          status = ST_DISALLOWED;
        end else begin
          status = ST_OK;
          nxt_o.adv_enabled = cmd_i.enable_request[0];
        end
      end
      OP_ADV_LEN, OP_SCAN_LEN: begin
        if (cmd_i.payload_length > MaxDataLen) begin
          status = ST_INVALID;
        end else begin
          status = ST_OK;
          if (op_e'(cmd_i.operation) == OP_ADV_LEN) begin
            nxt_o.adv_data_length = cmd_i.payload_length[LenW-1:0];
          end else begin
            nxt_o.scan_data_length = cmd_i.payload_length[LenW-1:0];
          end
        end
      end
      OP_RESET: begin
        status = ST_OK;
        nxt_o  = SettingsReset;
      end
      default: begin
        status = ST_INVALID;
      end
    endcase
  end

  assign rsp_o.status         = status;
  assign rsp_o.event_kind     = (status == ST_OK) ? EV_COMPLETE : EV_STATUS;
  assign rsp_o.advertising_on = nxt_o.adv_enabled;

endmodule

>>> sv/lacc_settings.sv
// Stored advertising settings with their reset values; load on a checked command.
// Depends on lacc_pkg.
module lacc_settings import lacc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  settings_t nxt_i,
  output settings_t cur_o
);

  settings_t settings_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings_q <= SettingsReset;
    end else if (load_i) begin
      settings_q <= nxt_i;
    end
  end

  assign cur_o = settings_q;

endmodule

>>> sv/le_advertising_command_checker.sv
// Top level of the LE advertising command checker: input register, checks,
// result register. Depends on lacc_pkg, lacc_if, lacc_check and lacc_settings.
//
// One command word goes in and one result word comes out for each command, in
// order. A command is taken into the input register, checked against the stored
// advertising settings by a single layer of comparators, and its result is
// registered in the result register once that register is free to take it. The
// stored settings are loaded together with the result word, so the following
// command in the input register already sees them: one command per cycle is
// sustained with no gaps while the result side takes each word. While a result
// word waits, the input register still takes one more command and then holds
// it; a stall on the result side backs up through both registers.
// Checks: set parameters is disallowed while advertising is on; intervals are
// range-checked against the floor of the advertising type (directed type checks
// the peer address type instead); then own address type, channel map and filter
// policy. Enable must be 0 or 1 and differ from the current flag. Data lengths
// are limited to 31. Reset restores every setting; unknown operations report
// invalid parameters. Successful commands answer with a command complete event,
// failures with a command status event.
module le_advertising_command_checker import lacc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  lacc_cmd_if.sink      cmd_i,
  lacc_rsp_if.source    rsp_o
);

  logic      in_valid_q;
  cmd_t      in_cmd_q;
  logic      out_valid_q;
  rsp_t      out_rsp_q;
  logic      out_free;
  logic      advance;
  rsp_t      rsp;
  settings_t cur;
  settings_t nxt;

  // Result register takes a new word when empty or being drained.
  assign out_free = !out_valid_q || rsp_o.ready;
  // Move a checked command into the result register; settings update with it.
  assign advance  = in_valid_q && out_free;
  assign cmd_i.ready = !in_valid_q || out_free;

  // Input register: hold the command until it can be checked and retired.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      in_cmd_q.operation         <= cmd_i.operation;
      in_cmd_q.interval_lo       <= cmd_i.interval_lo;
      in_cmd_q.interval_hi       <= cmd_i.interval_hi;
      in_cmd_q.adv_type          <= cmd_i.adv_type;
      in_cmd_q.own_address_kind  <= cmd_i.own_address_kind;
      in_cmd_q.peer_address_kind <= cmd_i.peer_address_kind;
      in_cmd_q.peer_address      <= cmd_i.peer_address;
      in_cmd_q.channel_select    <= cmd_i.channel_select;
      in_cmd_q.filter_mode       <= cmd_i.filter_mode;
      in_cmd_q.enable_request    <= cmd_i.enable_request;
      in_cmd_q.payload_length    <= cmd_i.payload_length;
    end
  end

  lacc_check u_check (
    .cmd_i (in_cmd_q),
    .cur_i (cur),
    .rsp_o (rsp),
    .nxt_o (nxt)
  );

  lacc_settings u_settings (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance),
    .nxt_i  (nxt),
    .cur_o  (cur)
  );

  // Result register: hold the word until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rsp_q <= rsp;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_rsp_q.status;
  assign rsp_o.event_kind     = out_rsp_q.event_kind;
  assign rsp_o.advertising_on = out_rsp_q.advertising_on;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for le_advertising_command_checker: drives command words,
// predicts each result word and compares them in order. Depends on lacc_pkg,
// lacc_if and the block's top level.
module tb_top import lacc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Operation codes that the block does not know and must refuse.
  localparam logic [OpW-1:0]   OpUnknownLow    = 3'd5;
  localparam logic [OpW-1:0]   OpUnknownHigh   = 3'd7;
  // Lowest advertising type value outside the defined set.
  localparam logic [ByteW-1:0] AdvTypeFirstBad = 8'd4;
  // Cycles without any handshake, while work is outstanding, before giving up.
  localparam int unsigned      StallLimit      = 2000;
  localparam int unsigned      RandomPerPhase  = 200;
  localparam int unsigned      ReportLimit     = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lacc_cmd_if cmd_bus ();
  lacc_rsp_if rsp_bus ();

  le_advertising_command_checker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .rsp_o  (rsp_bus)
  );

  // Command word on the wire and its valid; both start known at time zero.
  cmd_t cmd_word  = '0;
  logic cmd_valid = 1'b0;
  logic rsp_ready = 1'b0;

  assign cmd_bus.valid             = cmd_valid;
  assign cmd_bus.operation         = cmd_word.operation;
  assign cmd_bus.interval_lo       = cmd_word.interval_lo;
  assign cmd_bus.interval_hi       = cmd_word.interval_hi;
  assign cmd_bus.adv_type          = cmd_word.adv_type;
  assign cmd_bus.own_address_kind  = cmd_word.own_address_kind;
  assign cmd_bus.peer_address_kind = cmd_word.peer_address_kind;
  assign cmd_bus.peer_address      = cmd_word.peer_address;
  assign cmd_bus.channel_select    = cmd_word.channel_select;
  assign cmd_bus.filter_mode       = cmd_word.filter_mode;
  assign cmd_bus.enable_request    = cmd_word.enable_request;
  assign cmd_bus.payload_length    = cmd_word.payload_length;
  assign rsp_bus.ready             = rsp_ready;

  // Commands waiting to be driven, and the answers owed by the block, oldest first.
  cmd_t      command_queue[$];
  rsp_t      owed_answers[$];
  // Our own copy of the advertising settings, advanced once per accepted command.
  settings_t shadow_settings = SettingsReset;

  int unsigned tx_idle_pct    = 0;
  int unsigned rx_idle_pct    = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Both intervals inside [floor, IntervalHigh], and the low one not above the high one.
  function automatic logic interval_pair_ok(logic [IntervalW-1:0] floor_v,
                                            logic [IntervalW-1:0] lo,
                                            logic [IntervalW-1:0] hi);
    return (lo >= floor_v) && (lo <= IntervalHigh) &&
           (hi >= floor_v) && (hi <= IntervalHigh) && (lo <= hi);
  endfunction

  // Work out the answer to one command and advance the shadow settings.
  function automatic rsp_t advance_settings(cmd_t c);
    status_e st;
    rsp_t    answer;
    st = ST_OK;
    case (c.operation)
      OP_SET_PARAMS: begin
        // Refuse outright while advertising; then check in the block's order.
        if (shadow_settings.adv_enabled) begin
          st = ST_DISALLOWED;
        end else begin
          if (c.adv_type == 8'(ADV_IND)) begin
            if (!interval_pair_ok(IntervalLowConn, c.interval_lo, c.interval_hi)) begin
              st = ST_INVALID;
            end
          end else if (c.adv_type == 8'(ADV_DIRECT)) begin
            // Directed: intervals go unchecked; the peer address type is checked instead.
            if (c.peer_address_kind > 8'd1) st = ST_INVALID;
          end else if (c.adv_type == 8'(ADV_SCAN) || c.adv_type == 8'(ADV_NONCONN)) begin
            if (!interval_pair_ok(IntervalLowNonconn, c.interval_lo, c.interval_hi)) begin
              st = ST_INVALID;
            end
          end else begin
            st = ST_INVALID;
          end
          if (st == ST_OK && c.own_address_kind > 8'd1) st = ST_INVALID;
          if (st == ST_OK && (c.channel_select == 8'd0 ||
                              c.channel_select > 8'(ChannelsReset))) st = ST_INVALID;
          if (st == ST_OK && c.filter_mode > 8'd3) st = ST_INVALID;
          if (st == ST_OK) begin
            shadow_settings.interval_lo  = c.interval_lo;
            shadow_settings.interval_hi  = c.interval_hi;
            shadow_settings.adv_type     = c.adv_type[1:0];
            shadow_settings.own_kind     = c.own_address_kind[0];
            shadow_settings.peer_kind    = c.peer_address_kind;
            shadow_settings.peer_address = c.peer_address;
            shadow_settings.channels     = c.channel_select[2:0];
            shadow_settings.filter       = c.filter_mode[1:0];
          end
        end
      end
      OP_SET_ENABLE: begin
        if (c.enable_request > 8'd1) begin
          st = ST_INVALID;
        end else if (c.enable_request[0] == shadow_settings.adv_enabled) begin
          st = ST_DISALLOWED;
        end else begin
          shadow_settings.adv_enabled = c.enable_request[0];
        end
      end
      OP_ADV_LEN: begin
        if (c.payload_length > MaxDataLen) st = ST_INVALID;
        else shadow_settings.adv_data_length = c.payload_length[LenW-1:0];
      end
      OP_SCAN_LEN: begin
        if (c.payload_length > MaxDataLen) st = ST_INVALID;
        else shadow_settings.scan_data_length = c.payload_length[LenW-1:0];
      end
      OP_RESET: begin
        shadow_settings = SettingsReset;
      end
      default: begin
        st = ST_INVALID;
      end
    endcase
    answer.status         = st;
    answer.event_kind     = (st == ST_OK) ? EV_COMPLETE : EV_STATUS;
    answer.advertising_on = shadow_settings.adv_enabled;
    return answer;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  // Every field random over its full width.
  function automatic cmd_t noise_cmd();
    cmd_t c;
    c.operation         = OpW'($urandom);
    c.interval_lo       = IntervalW'($urandom);
    c.interval_hi       = IntervalW'($urandom);
    c.adv_type          = ByteW'($urandom);
    c.own_address_kind  = ByteW'($urandom);
    c.peer_address_kind = ByteW'($urandom);
    c.peer_address      = {16'($urandom), 32'($urandom)};
    c.channel_select    = ByteW'($urandom);
    c.filter_mode       = ByteW'($urandom);
    c.enable_request    = ByteW'($urandom);
    c.payload_length    = ByteW'($urandom);
    return c;
  endfunction

  // Set parameters with the given checked fields; the rest stay random.
  function automatic cmd_t params_cmd(logic [ByteW-1:0] ty, logic [IntervalW-1:0] lo,
                                      logic [IntervalW-1:0] hi, logic [ByteW-1:0] own,
                                      logic [ByteW-1:0] peer, logic [ByteW-1:0] chan,
                                      logic [ByteW-1:0] filt);
    cmd_t c;
    c = noise_cmd();
    c.operation         = OP_SET_PARAMS;
    c.adv_type          = ty;
    c.interval_lo       = lo;
    c.interval_hi       = hi;
    c.own_address_kind  = own;
    c.peer_address_kind = peer;
    c.channel_select    = chan;
    c.filter_mode       = filt;
    return c;
  endfunction

  // Any other operation, with its enable and length bytes given.
  function automatic cmd_t short_cmd(logic [OpW-1:0] op, logic [ByteW-1:0] en,
                                     logic [ByteW-1:0] len);
    cmd_t c;
    c = noise_cmd();
    c.operation      = op;
    c.enable_request = en;
    c.payload_length = len;
    return c;
  endfunction

  // Mostly well-formed commands with random content; the rest broken or noise.
  function automatic cmd_t random_command();
    cmd_t                 c;
    int unsigned          pick;
    logic [IntervalW-1:0] floor_v;
    c    = noise_cmd();
    pick = $urandom_range(99);
    if (pick < 40) begin
      c.operation = OP_SET_PARAMS;
      if ($urandom_range(99) < 80) begin
        c.adv_type = ByteW'($urandom_range(3));
        floor_v = (c.adv_type == 8'(ADV_IND)) ? IntervalLowConn : IntervalLowNonconn;
        c.interval_lo = IntervalW'($urandom_range(IntervalHigh, floor_v));
        if ($urandom_range(3) == 0) c.interval_lo = floor_v;
        c.interval_hi = IntervalW'($urandom_range(IntervalHigh, c.interval_lo));
        if ($urandom_range(3) == 0) c.interval_hi = IntervalHigh;
        c.own_address_kind  = ByteW'($urandom_range(1));
        c.peer_address_kind = ByteW'($urandom_range(1));
        c.channel_select    = ByteW'($urandom_range(7, 1));
        c.filter_mode       = ByteW'($urandom_range(3));
        // Break one check now and then, so that each stage of the check order fails.
        if ($urandom_range(4) == 0) begin
          case ($urandom_range(5))
            0: c.interval_lo       = IntervalW'($urandom);
            1: c.interval_hi       = IntervalW'($urandom);
            2: c.own_address_kind  = ByteW'($urandom_range(255, 2));
            3: c.channel_select    = ($urandom_range(1) == 0) ? 8'd0
                                                              : ByteW'($urandom_range(255, 8));
            4: c.filter_mode       = ByteW'($urandom_range(255, 4));
            default: c.peer_address_kind = ByteW'($urandom_range(255, 2));
          endcase
        end
      end
    end else if (pick < 65) begin
      c.operation = OP_SET_ENABLE;
      if ($urandom_range(9) < 8) c.enable_request = ByteW'($urandom_range(1));
    end else if (pick < 89) begin
      c.operation = (pick < 77) ? OP_ADV_LEN : OP_SCAN_LEN;
      if ($urandom_range(9) < 7) c.payload_length = ByteW'($urandom_range(MaxDataLen));
    end else if (pick < 94) begin
      c.operation = OP_RESET;
    end else begin
      c.operation = OpW'($urandom_range(OpUnknownHigh, OpUnknownLow));
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present one word at a time from the command queue
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid <= 1'b0;
    end else begin
      // Word taken at this edge: owe its answer from now on.
      if (cmd_valid && cmd_bus.ready) begin
        owed_answers.push_back(advance_settings(cmd_word));
      end
      // Hold a word that was not taken; otherwise load the next one or idle.
      if (!cmd_valid || cmd_bus.ready) begin
        if (command_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          cmd_word  <= command_queue.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result word with the oldest answer owed
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_ready) begin : check_word
        rsp_t want;
        if (owed_answers.size() == 0) begin
          flag_mismatch($sformatf("result word with nothing owed: status %0d event %0d adv %0d",
                                  rsp_bus.status, rsp_bus.event_kind, rsp_bus.advertising_on));
        end else begin
          want = owed_answers.pop_front();
          if (rsp_bus.status !== want.status ||
              rsp_bus.event_kind !== want.event_kind ||
              rsp_bus.advertising_on !== want.advertising_on) begin
            flag_mismatch($sformatf("expected status %0d event %0d adv %0d, got %0d %0d %0d",
                                    want.status, want.event_kind, want.advertising_on,
                                    rsp_bus.status, rsp_bus.event_kind,
                                    rsp_bus.advertising_on));
          end
        end
      end
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: count cycles with work outstanding but no handshake on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((cmd_valid && cmd_bus.ready) || (rsp_bus.valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else if (command_queue.size() != 0 || cmd_valid || owed_answers.size() != 0) begin
      stall_cycles <= stall_cycles + 1;
    end else begin
      stall_cycles <= 0;
    end
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("no progress for %0d cycles", StallLimit);
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------

  // Pause the sender until every word has been sent and answered.
  task automatic wait_drained();
    while (command_queue.size() != 0 || cmd_valid || owed_answers.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) command_queue.push_back(random_command());
    wait_drained();
  endtask

  initial begin
    tx_idle_pct = 18;
    rx_idle_pct = 82;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: interval floors and ceiling per type, directed type, each later
    // check, enable rules, length limit, reset and unknown operations.
    command_queue.push_back(params_cmd(8'(ADV_IND), IntervalLowConn, IntervalHigh,
                                       8'd0, 8'd0, 8'(ChannelsReset), 8'd0));
    command_queue.push_back(params_cmd(8'(ADV_IND), IntervalLowConn - 1'b1, IntervalHigh,
                                       8'd0, 8'd0, 8'd7, 8'd0));
    command_queue.push_back(params_cmd(8'(ADV_IND), IntervalLowConn, IntervalHigh + 1'b1,
                                       8'd0, 8'd0, 8'd7, 8'd0));
    command_queue.push_back(params_cmd(8'(ADV_IND), 16'h0100, 16'h00ff,
                                       8'd0, 8'd0, 8'd7, 8'd0));
    command_queue.push_back(params_cmd(8'(ADV_SCAN), IntervalLowNonconn, IntervalLowNonconn,
                                       8'd1, 8'd0, 8'd1, 8'd3));
    command_queue.push_back(params_cmd(8'(ADV_NONCONN), IntervalLowNonconn - 1'b1,
                                       16'h0200, 8'd0, 8'd0, 8'd7, 8'd0));
    // Directed type with intervals far outside any range, stored anyway.
    command_queue.push_back(params_cmd(8'(ADV_DIRECT), 16'h0000, 16'hffff,
                                       8'd1, 8'd1, 8'd7, 8'd2));
    command_queue.push_back(params_cmd(8'(ADV_DIRECT), IntervalReset, IntervalReset,
                                       8'd0, 8'hff, 8'd7, 8'd0));
    command_queue.push_back(params_cmd(AdvTypeFirstBad, IntervalReset, IntervalReset,
                                       8'd0, 8'd0, 8'd7, 8'd0));
    command_queue.push_back(params_cmd(8'hff, IntervalReset, IntervalReset,
                                       8'd0, 8'd0, 8'd7, 8'd0));
    command_queue.push_back(params_cmd(8'(ADV_IND), IntervalReset, IntervalReset,
                                       8'd2, 8'd0, 8'd7, 8'd0));
    command_queue.push_back(params_cmd(8'(ADV_IND), IntervalReset, IntervalReset,
                                       8'd0, 8'd0, 8'd0, 8'd0));
    command_queue.push_back(params_cmd(8'(ADV_IND), IntervalReset, IntervalReset,
                                       8'd0, 8'd0, 8'd8, 8'd0));
    command_queue.push_back(params_cmd(8'(ADV_IND), IntervalReset, IntervalReset,
                                       8'd0, 8'd0, 8'd7, 8'd4));
    command_queue.push_back(short_cmd(OP_SET_ENABLE, 8'd0, 8'd0));
    command_queue.push_back(short_cmd(OP_SET_ENABLE, 8'hff, 8'd0));
    command_queue.push_back(short_cmd(OP_SET_ENABLE, 8'd1, 8'd0));
    command_queue.push_back(short_cmd(OP_SET_ENABLE, 8'd1, 8'd0));
    // Parameters while advertising: refused, nothing stored.
    command_queue.push_back(params_cmd(8'(ADV_IND), IntervalLowConn, IntervalHigh,
                                       8'd0, 8'd0, 8'd7, 8'd0));
    command_queue.push_back(short_cmd(OP_ADV_LEN, 8'd0, MaxDataLen));
    command_queue.push_back(short_cmd(OP_ADV_LEN, 8'd0, MaxDataLen + 1'b1));
    command_queue.push_back(short_cmd(OP_SCAN_LEN, 8'd0, 8'hff));
    command_queue.push_back(short_cmd(OP_SCAN_LEN, 8'd0, 8'd0));
    command_queue.push_back(short_cmd(OP_RESET, 8'hff, 8'hff));
    command_queue.push_back(short_cmd(OpUnknownLow, 8'd0, 8'd0));
    command_queue.push_back(short_cmd(OpUnknownHigh, 8'd1, 8'd1));
    command_queue.push_back(short_cmd(OP_SET_ENABLE, 8'd0, 8'd0));
    wait_drained();

    // Random: sender mostly busy, receiver mostly stalling.
    send_random(RandomPerPhase);
    // Swap the pressure round.
    tx_idle_pct = 82;
    rx_idle_pct = 18;
    send_random(RandomPerPhase);
    // Back to back on both sides.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(RandomPerPhase);

    // Leave room for any stray result word before the verdict.
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && owed_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lacc_pkg.sv
sv/lacc_if.sv
sv/lacc_check.sv
sv/lacc_settings.sv
sv/le_advertising_command_checker.sv
tb/tb_top.sv
